// ===== hdl/pgs_rle_pkg.sv =====
// ----------------------------------------------------------------------------
// PGS RLE package
// Shared payload types, opcodes and parser phase codes for the presentation
// graphics run-length decoder.
// ----------------------------------------------------------------------------
package pgs_rle_pkg;

  // Input item opcodes
  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_PALETTE = 2'd1;
  localparam logic [1:0] OP_NEW_OBJ = 2'd2;

  // Switch byte layout
  localparam int unsigned SW_COLOR_BIT = 7;
  localparam int unsigned SW_LONG_BIT  = 6;

  localparam int unsigned COUNT_W = 14;

  typedef enum logic [3:0] {
    PH_FIRST  = 4'b0001,
    PH_SWITCH = 4'b0010,
    PH_LOW    = 4'b0100,
    PH_COLOR  = 4'b1000
  } pgs_phase_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic [7:0]  entry_index;
    logic [31:0] entry_color;
  } pgs_in_t;

  typedef struct packed {
    logic [15:0]        column;
    logic [15:0]        row;
    logic [COUNT_W-1:0] run_length;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } pgs_out_t;

endpackage

// ===== hdl/pgs_rle_palette.sv =====
// ----------------------------------------------------------------------------
// PGS RLE palette store
// Palette memory with one write and one registered read port. A per-entry
// valid bit, cleared at reset, makes unwritten entries read as zero.
// ----------------------------------------------------------------------------
module pgs_rle_palette #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr_i,
  input  logic [31:0]                wr_data_i,
  input  logic                       rd_en_i,
  input  logic                       rd_in_range_i,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr_i,
  output logic [31:0]                rd_data_o
);

  logic [31:0]        mem [ENTRIES];
  logic [31:0]        rdata_q;
  logic [ENTRIES-1:0] written_q;
  logic               hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      hit_q     <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= rd_in_range_i && written_q[rd_addr_i];
      end
    end
  end

  // Entry never written or index beyond the store: zero color
  assign rd_data_o = hit_q ? rdata_q : '0;

endmodule

// ===== hdl/pgs_rle_run_decoder_core.sv =====
// ----------------------------------------------------------------------------
// PGS RLE run decoder core
// Decodes presentation graphics run-length object data, one coded byte per
// transfer, into runs of column, row, length and palette color.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one item per transfer: coded byte, palette write or new object.
//   out_*  : one run per transfer, only for coded bytes that close a nonzero
//            run; line ends, partial codes and other items give nothing.
//   cfg_*  : object height write, always ready; write only while idle.
// Throughput: one input item per cycle while the output side is not stalled.
// Path: the run that a byte completes waits in the result stage while the
//   palette read register is loaded, then moves to the output register,
//   which presents it on out_valid_o.
// Stall: a result stage and the output register decouple the two sides;
//   input keeps flowing until both hold runs the receiver has not taken.
// Reset: parser, column, row and height clear; every palette entry reads
//   as zero until written. No clearing pass, the block is ready at once.
// ----------------------------------------------------------------------------
module pgs_rle_run_decoder_core #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pgs_rle_pkg::pgs_in_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pgs_rle_pkg::pgs_out_t out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [15:0]          cfg_data_i
);

  import pgs_rle_pkg::*;

  localparam int unsigned AddrW = $clog2(PALETTE_ENTRIES);

  // Parser and position state
  pgs_phase_e         phase_q, phase_d;
  logic [5:0]         high_q, high_d;
  logic               long_q, long_d;
  logic               expl_q, expl_d;
  logic [COUNT_W-1:0] held_q, held_d;
  logic [15:0]        col_q, col_d;
  logic [15:0]        row_q, row_d;
  logic [15:0]        height_q;

  // Result stage (waits on palette read) and output register
  logic               s1_valid_q;
  logic [15:0]        s1_col_q;
  logic [15:0]        s1_row_q;
  logic [COUNT_W-1:0] s1_len_q;
  logic               out_valid_q;
  pgs_out_t           out_data_q;

  logic               in_fire;
  logic               s1_adv;
  logic               work;
  logic               fin;
  logic [COUNT_W-1:0] fin_count;
  logic [7:0]         fin_idx;
  logic               emit;
  logic               pal_wr;
  logic [31:0]        pal_color;
  logic [COUNT_W-1:0] long_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= '0;
    end else if (cfg_valid_i) begin
      height_q <= cfg_data_i;
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // Coded bytes are dropped once the row reaches the object height
  assign work = in_fire && (in_data_i.opcode == OP_DATA) && (row_q < height_q);

  assign long_count = {high_q, in_data_i.data_byte};

  always_comb begin
    phase_d   = phase_q;
    high_d    = high_q;
    long_d    = long_q;
    expl_d    = expl_q;
    held_d    = held_q;
    col_d     = col_q;
    row_d     = row_q;
    fin       = 1'b0;
    fin_count = '0;
    fin_idx   = '0;
    emit      = 1'b0;

    if (in_fire && (in_data_i.opcode == OP_NEW_OBJ)) begin
      phase_d = PH_FIRST;
      high_d  = '0;
      long_d  = 1'b0;
      expl_d  = 1'b0;
      held_d  = '0;
      col_d   = '0;
      row_d   = '0;
    end else if (work) begin
      unique case (phase_q)
        PH_FIRST: begin
          if (in_data_i.data_byte != 8'd0) begin
            fin       = 1'b1;
            fin_count = COUNT_W'(1);
            fin_idx   = in_data_i.data_byte;
          end else begin
            phase_d = PH_SWITCH;
          end
        end
        PH_SWITCH: begin
          long_d = in_data_i.data_byte[SW_LONG_BIT];
          expl_d = in_data_i.data_byte[SW_COLOR_BIT];
          high_d = in_data_i.data_byte[5:0];
          if (in_data_i.data_byte[SW_LONG_BIT]) begin
            phase_d = PH_LOW;
          end else begin
            held_d = COUNT_W'(in_data_i.data_byte[5:0]);
            if (in_data_i.data_byte[SW_COLOR_BIT]) begin
              phase_d = PH_COLOR;
            end else begin
              fin       = 1'b1;
              fin_count = COUNT_W'(in_data_i.data_byte[5:0]);
            end
          end
        end
        PH_LOW: begin
          held_d = long_count;
          if (expl_q) begin
            phase_d = PH_COLOR;
          end else begin
            fin       = 1'b1;
            fin_count = long_count;
          end
        end
        PH_COLOR: begin
          fin       = 1'b1;
          fin_count = held_q;
          fin_idx   = in_data_i.data_byte;
        end
        default: begin
          phase_d = PH_FIRST;
        end
      endcase

      // Close the code: zero count ends the line, otherwise emit the run
      if (fin) begin
        phase_d = PH_FIRST;
        if (fin_count == '0) begin
          row_d = row_q + 16'd1;
          col_d = '0;
        end else begin
          emit  = 1'b1;
          col_d = col_q + 16'(fin_count);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      high_q  <= '0;
      long_q  <= 1'b0;
      expl_q  <= 1'b0;
      held_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      phase_q <= phase_d;
      high_q  <= high_d;
      long_q  <= long_d;
      expl_q  <= expl_d;
      held_q  <= held_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  assign pal_wr = in_fire && (in_data_i.opcode == OP_PALETTE) &&
                  ({1'b0, in_data_i.entry_index} < 9'(PALETTE_ENTRIES));

  pgs_rle_palette #(
    .ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (pal_wr),
    .wr_addr_i    (in_data_i.entry_index[AddrW-1:0]),
    .wr_data_i    (in_data_i.entry_color),
    .rd_en_i      (emit),
    .rd_in_range_i({1'b0, fin_idx} < 9'(PALETTE_ENTRIES)),
    .rd_addr_i    (fin_idx[AddrW-1:0]),
    .rd_data_o    (pal_color)
  );

  // Result stage: hold the run geometry while the palette read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (emit) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_col_q <= col_q;
      s1_row_q <= row_q;
      s1_len_q <= fin_count;
    end
  end

  // Output register: advance on an empty slot or a completed transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q.column     <= s1_col_q;
      out_data_q.row        <= s1_row_q;
      out_data_q.run_length <= s1_len_q;
      out_data_q.red        <= pal_color[7:0];
      out_data_q.green      <= pal_color[15:8];
      out_data_q.blue       <= pal_color[23:16];
      out_data_q.alpha      <= pal_color[31:24];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
